>>> src/hpc_pkg.sv
package hpc_pkg;

  typedef enum logic [1:0] {
    OP_HALF_TO_SINGLE = 2'd0,
    OP_SINGLE_TO_HALF = 2'd1,
    OP_BF16_TO_SINGLE = 2'd2,
    OP_SINGLE_TO_BF16 = 2'd3
  } op_t;

  localparam int unsigned OpWidth   = 2;
  localparam int unsigned WordWidth = 32;

  // Difference between the single and half exponent biases (127 - 15).
  localparam logic [7:0] HalfBiasGap   = 8'd112;
  localparam logic [7:0] SingleExpMax  = 8'hFF;
  localparam logic [4:0] HalfExpMax    = 5'h1F;
  // Single exponents that bound the half range.
  localparam logic [7:0] HalfOvfExp    = 8'd142;
  localparam logic [7:0] HalfTinyExp   = 8'd103;
  localparam logic [7:0] HalfNormExp   = 8'd113;
  // Right shift for a half subnormal is this minus the single exponent.
  localparam logic [7:0] HalfSubShBase = 8'd126;
  // Single exponent of a half subnormal whose leading one is at bit 0.
  localparam logic [7:0] HalfSubExpBase = 8'd103;
  localparam logic [31:0] Bf16RoundBias = 32'h0000_7FFF;
  localparam logic [15:0] Bf16QuietBit  = 16'h0040;

endpackage

>>> src/hpc_convert.sv
module hpc_convert
  import hpc_pkg::*;
(
  input  op_t              op,
  input  logic [WordWidth-1:0] operand,
  output logic [WordWidth-1:0] result
);

  // Half operand fields.
  logic       h_sgn;
  logic [4:0] h_exp;
  logic [9:0] h_man;
  logic [3:0] lead_pos;
  logic [3:0] sub_shift;
  logic [9:0] sub_man;
  logic [7:0] sub_exp;
  logic [31:0] h2s;

  // Single operand fields.
  logic        f_sgn;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [7:0]  f_sub_sh;
  logic [23:0] f_sub_val;
  logic [4:0]  f_half_exp;
  logic [15:0] s2h;

  logic [31:0] rounded;
  logic [15:0] s2b;

  assign h_sgn = operand[15];
  assign h_exp = operand[14:10];
  assign h_man = operand[9:0];

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  // A subnormal half is normalized so that its leading one lands on the hidden bit.
  assign sub_shift = 4'd10 - lead_pos;
  assign sub_man   = h_man << sub_shift;
  assign sub_exp   = HalfSubExpBase + {4'b0, lead_pos};

  always_comb begin
    if (h_exp == '0) begin
      if (h_man == '0) begin
        h2s = {h_sgn, 31'b0};
      end else begin
        h2s = {h_sgn, sub_exp, sub_man, 13'b0};
      end
    end else if (h_exp == HalfExpMax) begin
      h2s = {h_sgn, SingleExpMax, h_man, 13'b0};
    end else begin
      h2s = {h_sgn, HalfBiasGap + {3'b0, h_exp}, h_man, 13'b0};
    end
  end

  assign f_sgn = operand[31];
  assign f_exp = operand[30:23];
  assign f_man = operand[22:0];

  assign f_sub_sh   = HalfSubShBase - f_exp;
  assign f_sub_val  = {1'b1, f_man} >> f_sub_sh[4:0];
  assign f_half_exp = 5'(f_exp - HalfBiasGap);

  always_comb begin
    if (f_exp == SingleExpMax) begin
      s2h = {f_sgn, HalfExpMax, f_man[22:13]};
    end else if (f_exp > HalfOvfExp) begin
      s2h = {f_sgn, HalfExpMax, 10'b0};
    end else if (f_exp < HalfTinyExp) begin
      s2h = {f_sgn, 15'b0};
    end else if (f_exp < HalfNormExp) begin
      s2h = {f_sgn, 5'b0, f_sub_val[9:0]};
    end else begin
      s2h = {f_sgn, f_half_exp, f_man[22:13]};
    end
  end

  // Adding the bias plus the kept LSB rounds half to even on the upper 16 bits.
  assign rounded = operand + Bf16RoundBias + {31'b0, operand[16]};

  always_comb begin
    if (f_exp == SingleExpMax && f_man != '0) begin
      s2b = operand[31:16] | Bf16QuietBit;
    end else begin
      s2b = rounded[31:16];
    end
  end

  always_comb begin
    case (op)
      OP_HALF_TO_SINGLE: result = h2s;
      OP_SINGLE_TO_HALF: result = {16'b0, s2h};
      OP_BF16_TO_SINGLE: result = {operand[15:0], 16'b0};
      OP_SINGLE_TO_BF16: result = {16'b0, s2b};
      default:           result = '0;
    endcase
  end

endmodule

>>> src/half_precision_cast_unit.sv
// Cast unit between IEEE single, IEEE half and bfloat16 bit patterns.
// Input items arrive on the s_ channel: s_tuser selects the operation
// (half to single, single to half, bf16 to single, single to bf16) and
// s_tdata holds the operand; 16-bit operands sit in bits 15..0.
// Each item gives exactly one result item on the m_ channel, with 16-bit
// results zero-extended in bits 15..0 of m_tdata.
// An item passes an input register, the conversion logic and a result
// register. One item is accepted every cycle while m_tready is high.
// When m_tready is low a full result register holds; the input register
// keeps taking an item until it is also full, after which s_tready drops.
// s_tready is always high while m_tready is high.
// Reset empties both registers; no item is lost or repeated across a stall.
module half_precision_cast_unit
  import hpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [WordWidth-1:0] s_tdata,  // [31:0] operand_bits
  input  logic [OpWidth-1:0]   s_tuser,  // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [WordWidth-1:0] m_tdata   // [31:0] result_bits
);

  logic                 in_valid;
  op_t                  in_op;
  logic [WordWidth-1:0] in_operand;
  logic                 in_ready;
  logic [WordWidth-1:0] conv_result;

  assign in_ready = !m_tvalid || m_tready;
  assign s_tready = !in_valid || in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op      <= op_t'(s_tuser);
      in_operand <= s_tdata;
    end
  end

  hpc_convert u_convert (
    .op      (in_op),
    .operand (in_operand),
    .result  (conv_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tdata <= conv_result;
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled although the output is draining");

  assert property (@(posedge clk) disable iff (rst) !in_valid && !m_tvalid |-> s_tready)
    else $error("empty pipeline refuses an item");

  assert property (@(posedge clk) disable iff (rst) in_valid && !in_ready |=> in_valid)
    else $error("stalled item dropped from the input register");

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tready |=> in_valid)
    else $error("accepted item did not reach the input register");

  assert property (@(posedge clk) rst |=> !m_tvalid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> test/half_precision_cast_unit_tb.sv
`timescale 1ns / 100ps

module half_precision_cast_unit_tb;
  import hpc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 1500;
  localparam int HoldCycles = 300;

  typedef struct {
    op_t             op;
    logic [31:0]     operand;
    bit              known;
    logic [31:0]     result;
  } cast_case_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WordWidth-1:0] s_tdata = '0;  // [31:0] operand_bits
  logic [OpWidth-1:0]   s_tuser = '0;  // [1:0] req_type
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WordWidth-1:0] m_tdata;       // [31:0] result_bits

  logic [31:0] pending_results[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Expected values are typed in only where they are plain from the formats.
  cast_case_t directed_cases [26] = '{
    '{OP_HALF_TO_SINGLE, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_8000, 1'b1, 32'h8000_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_3C00, 1'b1, 32'h3F80_0000},
    '{OP_HALF_TO_SINGLE, 32'hFFFF_3C00, 1'b1, 32'h3F80_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_7C00, 1'b1, 32'h7F80_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_FC00, 1'b1, 32'hFF80_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_7E00, 1'b1, 32'h7FC0_0000},
    '{OP_HALF_TO_SINGLE, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_HALF_TO_SINGLE, 32'h0000_83FF, 1'b0, 32'h0},
    '{OP_HALF_TO_SINGLE, 32'h0000_7BFF, 1'b0, 32'h0},
    '{OP_SINGLE_TO_HALF, 32'h3F80_0000, 1'b1, 32'h0000_3C00},
    '{OP_SINGLE_TO_HALF, 32'hFF80_0000, 1'b1, 32'h0000_FC00},
    '{OP_SINGLE_TO_HALF, 32'h7F80_0001, 1'b1, 32'h0000_7C00},
    '{OP_SINGLE_TO_HALF, 32'hFFFF_FFFF, 1'b1, 32'h0000_FFFF},
    '{OP_SINGLE_TO_HALF, 32'h4780_0000, 1'b1, 32'h0000_7C00},
    '{OP_SINGLE_TO_HALF, 32'h477F_FFFF, 1'b0, 32'h0},
    '{OP_SINGLE_TO_HALF, 32'hB300_0000, 1'b1, 32'h0000_8000},
    '{OP_SINGLE_TO_HALF, 32'h0000_0001, 1'b1, 32'h0000_0000},
    '{OP_SINGLE_TO_HALF, 32'h3380_0000, 1'b0, 32'h0},
    '{OP_SINGLE_TO_HALF, 32'h387F_FFFF, 1'b0, 32'h0},
    '{OP_BF16_TO_SINGLE, 32'hABCD_1234, 1'b1, 32'h1234_0000},
    '{OP_BF16_TO_SINGLE, 32'h0000_FFFF, 1'b1, 32'hFFFF_0000},
    '{OP_SINGLE_TO_BF16, 32'h3F80_8000, 1'b0, 32'h0},
    '{OP_SINGLE_TO_BF16, 32'h3F81_8000, 1'b0, 32'h0},
    '{OP_SINGLE_TO_BF16, 32'h7F80_0001, 1'b1, 32'h0000_7FC0},
    '{OP_SINGLE_TO_BF16, 32'h7F7F_FFFF, 1'b0, 32'h0}
  };

  half_precision_cast_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] cast_word(op_t op, logic [31:0] v);
    logic [31:0] r;
    logic        sgn;
    logic [10:0] hman;
    logic [7:0]  sexp;
    logic [23:0] full_man;
    logic [31:0] sum;
    int          shifts;
    int          unb;
    r = '0;
    case (op)
      OP_HALF_TO_SINGLE: begin
        sgn  = v[15];
        hman = {1'b0, v[9:0]};
        if (v[14:10] == 5'd0) begin
          if (hman == 11'd0) begin
            r = {sgn, 31'b0};
          end else begin
            // Normalize so the leading one lands on the hidden bit.
            shifts = 0;
            while (!hman[10]) begin
              hman = hman << 1;
              shifts++;
            end
            r = {sgn, 8'(HalfBiasGap + 1 - shifts), hman[9:0], 13'b0};
          end
        end else if (v[14:10] == HalfExpMax) begin
          r = {sgn, SingleExpMax, v[9:0], 13'b0};
        end else begin
          r = {sgn, {3'b0, v[14:10]} + HalfBiasGap, v[9:0], 13'b0};
        end
      end
      OP_SINGLE_TO_HALF: begin
        sgn      = v[31];
        sexp     = v[30:23];
        full_man = {1'b1, v[22:0]};
        unb      = int'(sexp) - 127;
        if (sexp == SingleExpMax) begin
          r = {16'b0, sgn, HalfExpMax, v[22:13]};
        end else if (unb > 15) begin
          r = {16'b0, sgn, HalfExpMax, 10'b0};
        end else if (unb < -24) begin
          r = {16'b0, sgn, 15'b0};
        end else if (unb < -14) begin
          // Half subnormal: bits shifted past the bottom are dropped.
          r = {16'b0, sgn, 15'(full_man >> (-unb - 1))};
        end else begin
          r = {16'b0, sgn, 5'(unb + 15), v[22:13]};
        end
      end
      OP_BF16_TO_SINGLE: begin
        r = {v[15:0], 16'b0};
      end
      default: begin
        if (v[30:23] == SingleExpMax && v[22:0] != 23'd0) begin
          r = {16'b0, v[31:16] | Bf16QuietBit};
        end else begin
          sum = v + Bf16RoundBias + {31'b0, v[16]};
          r   = {16'b0, sum[31:16]};
        end
      end
    endcase
    return r;
  endfunction

  // Bias the operand toward exponent boundaries and rounding ties.
  function automatic logic [31:0] make_operand(op_t op);
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(3) == 0) return v;
    case (op)
      OP_HALF_TO_SINGLE: begin
        case ($urandom_range(2))
          0:       v[14:10] = 5'd0;
          1:       v[14:10] = HalfExpMax;
          default: ;
        endcase
      end
      OP_SINGLE_TO_HALF: begin
        case ($urandom_range(3))
          0:       v[30:23] = 8'($urandom_range(98, 146));
          1:       v[30:23] = 8'd0;
          2:       v[30:23] = SingleExpMax;
          default: ;
        endcase
        if ($urandom_range(3) == 0) v[12:0] = '0;
      end
      OP_SINGLE_TO_BF16: begin
        case ($urandom_range(3))
          0:       v[15:0] = 16'h7FFF;
          1:       v[15:0] = 16'h8000;
          2:       v[30:23] = SingleExpMax;
          default: ;
        endcase
        if ($urandom_range(7) == 0) v[22:0] = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input logic [31:0] got);
    logic [31:0] want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected item, result_bits %h", got));
    end else begin
      want = pending_results.pop_front();
      if (got !== want)
        report_mismatch($sformatf("result_bits got %h, want %h", got, want));
    end
  endtask

  // Offers one item, waits for it to be taken, then maybe leaves a gap.
  task automatic send_item(input op_t op, input logic [31:0] v, input bit known,
                           input logic [31:0] result);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(known ? result : cast_word(op, v));
    if (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 19);
    end
  end

  initial begin
    op_t op;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_cases[i])
      send_item(directed_cases[i].op, directed_cases[i].operand, directed_cases[i].known,
                directed_cases[i].result);
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 300) calm = 1'b1;
      if (i == 500) calm = 1'b0;
      // The sink holds off while the source keeps offering items.
      if (i == 700) hold_req++;
      op = op_t'($urandom_range(3));
      send_item(op, make_operand(op), 1'b0, '0);
      if (i == 900) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
